FILE: src/lbs_pkg.sv
package lbs_pkg;

    localparam int MAX_BANDS     = 16;
    localparam int BAND_W        = 4;
    localparam int MAX_MULTIPOLE = 256;
    localparam int ELL_W         = 9;
    localparam int DEN_W         = 18;
    localparam int DIV_STEPS     = 57;
    localparam int MUL_W         = 48;
    localparam int PROD_W        = 96;
    localparam int CORDIC_STEPS  = 20;
    localparam int CW            = 33;
    localparam int AW            = 27;

    localparam logic signed [AW-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [AW-1:0] TWO_TURN     = 27'sd47185920;
    localparam logic signed [AW-1:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [AW-1:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 33'sd652032875;
    localparam logic signed [63:0]   Q30_ONE      = 64'sd1073741824;
    localparam logic signed [47:0]   Q40_ONE      = 48'sd1099511627776;
    localparam logic signed [63:0]   S48_MAX      = 64'sd140737488355327;
    localparam logic signed [63:0]   S48_MIN      = -64'sd140737488355328;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } lbs_prod_t;

    typedef struct packed {
        logic              flip;
        logic signed [AW-1:0] m;
    } lbs_angle_t;

    function automatic logic signed [AW-1:0] atan_deg(input logic [4:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117308;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Product shifted right and rounded toward zero.
    function automatic logic signed [63:0] trunc_shift(input lbs_prod_t p, input int sh);
        logic [PROD_W-1:0] s;
        logic [63:0]       r;
        s = p.mag >> sh;
        r = s[63:0];
        return p.neg ? $signed(-r) : $signed(r);
    endfunction

    // Product shifted right by 30 with floor rounding.
    function automatic logic signed [63:0] floor30(input lbs_prod_t p);
        logic [PROD_W-1:0] s;
        logic [63:0]       r;
        s = p.mag >> 30;
        r = s[63:0];
        if (p.neg)
            r = -(r + {63'b0, |p.mag[29:0]});
        return $signed(r);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > S48_MAX)
            r = S48_MAX[47:0];
        else if (v < S48_MIN)
            r = S48_MIN[47:0];
        else
            r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else
            r = s[63:0];
        return r;
    endfunction

    // Brings an angle in [-720, 720) degrees into [-90, 90] degrees, noting a fold through 180.
    function automatic lbs_angle_t reduce_angle(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] p1;
        logic signed [AW-1:0] p2;
        logic signed [AW-1:0] m1;
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] h;
        lbs_angle_t           o;
        p1 = a + FULL_TURN;
        p2 = a + TWO_TURN;
        m1 = a - FULL_TURN;
        if (a < 0)
            r = (p1 < 0) ? p2 : p1;
        else
            r = (a >= FULL_TURN) ? m1 : a;
        h = (r >= HALF_TURN) ? r - FULL_TURN : r;
        if (h > QUARTER_TURN) begin
            o.m    = HALF_TURN - h;
            o.flip = 1'b1;
        end
        else if (h < -QUARTER_TURN) begin
            o.m    = -HALF_TURN - h;
            o.flip = 1'b1;
        end
        else begin
            o.m    = h;
            o.flip = 1'b0;
        end
        return o;
    endfunction

endpackage

FILE: src/legendre_band_signal.sv
// Band-summed Legendre signal for a pair of sky positions.
// Input words arrive on in_valid/in_stall. A word with action 0 writes one
// band table entry. A word with action 1 carries two positions; the block
// then stalls its input until every band result of that pair has been loaded
// into the output register.
// Results leave on out_valid/out_stall, one word per band in use, in band
// order; the final word has last set and carries the weighted total. While
// the receiver stalls, the output word holds and the sequencer waits.
// Work on a pair: three CORDIC rotations and three products, then a Legendre
// recurrence step for every multipole up to the end of the last band, then
// the band results. A recurrence step uses up to two divisions on the shared
// bit-serial divider and up to five products on the shared multiplier, which
// builds each 48x48 product from four 24x24 partial products.
// band_count is written over the APB port at address 0 and resets to 1.
// Reset empties the output register and returns the sequencer to idle; the
// band table holds nothing defined until it is written.
module legendre_band_signal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [0:0]         action,
    input  logic [3:0]         band_slot,
    input  logic [8:0]         band_first,
    input  logic [8:0]         band_last,
    input  logic signed [47:0] band_gain,
    input  logic [24:0]        ra_a,
    input  logic signed [23:0] dec_a,
    input  logic [24:0]        ra_b,
    input  logic signed [23:0] dec_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         band_index,
    output logic signed [47:0] band_signal,
    output logic signed [63:0] weighted_total,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lbs_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RED  = 5'd1;
    localparam logic [4:0] S_ROT  = 5'd2;
    localparam logic [4:0] S_X1   = 5'd3;
    localparam logic [4:0] S_X2   = 5'd4;
    localparam logic [4:0] S_X3   = 5'd5;
    localparam logic [4:0] S_LTOP = 5'd6;
    localparam logic [4:0] S_M1   = 5'd7;
    localparam logic [4:0] S_M2   = 5'd8;
    localparam logic [4:0] S_M3   = 5'd9;
    localparam logic [4:0] S_D1   = 5'd10;
    localparam logic [4:0] S_UPD  = 5'd11;
    localparam logic [4:0] S_T1   = 5'd12;
    localparam logic [4:0] S_T2   = 5'd13;
    localparam logic [4:0] S_G    = 5'd14;
    localparam logic [4:0] S_NEXT = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;

    localparam int CNT_W = BAND_W + 1;

    logic [4:0]           state_reg;
    logic [CNT_W-1:0]     band_count_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 issued_reg;
    logic                 out_valid_reg;

    logic signed [23:0]   deca_reg;
    logic signed [23:0]   decb_reg;
    logic signed [25:0]   rad_reg;
    logic [1:0]           cidx_reg;
    logic [4:0]           step_reg;
    logic                 flip_reg;
    logic signed [AW-1:0] cm_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic signed [CW-1:0] sa_reg;
    logic signed [CW-1:0] ca_reg;
    logic signed [CW-1:0] sb_reg;
    logic signed [CW-1:0] cb_reg;
    logic signed [CW-1:0] cd_reg;
    logic signed [47:0]   t1_reg;
    logic signed [47:0]   t2_reg;

    logic signed [47:0]   pair_cosine_reg;
    logic signed [47:0]   legendre_prev_reg;
    logic signed [47:0]   legendre_prev2_reg;
    logic [ELL_W-1:0]     multipole_count_reg;
    logic [ELL_W-1:0]     stop_reg;
    logic [DEN_W-1:0]     dl_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [BAND_W-1:0]    b_reg;
    logic signed [47:0]   cur_reg;
    logic signed [47:0]   m_reg;
    logic signed [63:0]   p1_reg;
    logic signed [63:0]   n_reg;
    logic signed [63:0]   total_reg;
    logic signed [63:0]   acc_reg [MAX_BANDS];

    logic [ELL_W-1:0]     first_table [MAX_BANDS];
    logic [ELL_W-1:0]     last_table  [MAX_BANDS];
    logic signed [47:0]   gain_table  [MAX_BANDS];
    logic [ELL_W-1:0]     rd_first_reg;
    logic [ELL_W-1:0]     rd_last_reg;
    logic signed [47:0]   rd_gain_reg;
    logic [BAND_W-1:0]    rd_addr;

    logic [3:0]           ob_index_reg;
    logic signed [47:0]   ob_signal_reg;
    logic signed [63:0]   ob_total_reg;
    logic                 ob_last_reg;

    logic                 accept;
    logic                 cfg_write;
    logic                 is_mul;
    logic                 is_div;
    logic                 mul_start;
    logic                 div_start;
    logic                 mul_done;
    logic                 div_done;
    lbs_prod_t            prod;
    logic signed [63:0]   quo;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [63:0]   div_num;
    logic [DEN_W-1:0]     div_den;

    logic [CNT_W-1:0]     count_in;
    logic [CNT_W-1:0]     count_m1;
    logic signed [AW-1:0] angle_src;
    lbs_angle_t           red;
    logic signed [CW-1:0] shx;
    logic signed [CW-1:0] shy;
    logic signed [CW-1:0] cx_next;
    logic signed [CW-1:0] cy_next;
    logic signed [AW-1:0] cm_next;
    logic signed [CW-1:0] cos_out;
    logic signed [63:0]   xsum;
    logic signed [63:0]   xclamp;
    logic [BAND_W-1:0]    acc_idx;
    logic signed [63:0]   acc_rd;
    logic [9:0]           two_l_m1;
    logic [9:0]           two_l_p1;
    logic [ELL_W-1:0]     l_m1;
    logic                 emit_load;
    logic                 emit_fin;
    logic                 takes_term;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, band_count_reg} : 32'd0;

    assign count_in  = (band_count_reg > CNT_W'(MAX_BANDS)) ? CNT_W'(MAX_BANDS) : band_count_reg;
    assign count_m1  = count_reg - CNT_W'(1);

    // Angle reduction and one CORDIC rotation step.
    always_comb
    begin
        case (cidx_reg)
            2'd0:    angle_src = AW'(deca_reg);
            2'd1:    angle_src = AW'(decb_reg);
            default: angle_src = AW'(rad_reg);
        endcase
    end

    assign red = reduce_angle(angle_src);
    assign shx = cx_reg >>> step_reg;
    assign shy = cy_reg >>> step_reg;

    always_comb
    begin
        if (cm_reg >= 0) begin
            cx_next = cx_reg - shy;
            cy_next = cy_reg + shx;
            cm_next = cm_reg - atan_deg(step_reg);
        end
        else begin
            cx_next = cx_reg + shy;
            cy_next = cy_reg - shx;
            cm_next = cm_reg + atan_deg(step_reg);
        end
    end

    assign cos_out = flip_reg ? -cx_next : cx_next;

    assign xsum   = 64'(t1_reg) + floor30(prod);
    assign xclamp = (xsum > Q30_ONE) ? Q30_ONE : ((xsum < -Q30_ONE) ? -Q30_ONE : xsum);

    assign two_l_m1 = {multipole_count_reg, 1'b0} - 10'd1;
    assign two_l_p1 = {multipole_count_reg, 1'b1};
    assign l_m1     = multipole_count_reg - ELL_W'(1);

    assign acc_idx = (state_reg == S_EMIT) ? b_reg : k_reg[BAND_W-1:0];
    assign acc_rd  = acc_reg[acc_idx];

    assign takes_term = (k_reg < count_reg) && (multipole_count_reg >= rd_first_reg);

    // Shared multiplier and divider operand selection.
    always_comb
    begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_X1:    begin mul_a = MUL_W'(sa_reg);  mul_b = MUL_W'(sb_reg); end
            S_X2:    begin mul_a = MUL_W'(ca_reg);  mul_b = MUL_W'(cb_reg); end
            S_X3:    begin mul_a = t2_reg;          mul_b = MUL_W'(cd_reg); end
            S_M1:    begin mul_a = pair_cosine_reg; mul_b = legendre_prev_reg; end
            S_M2:    begin mul_a = $signed({38'b0, two_l_m1}); mul_b = m_reg; end
            S_M3:    begin mul_a = $signed({39'b0, l_m1}); mul_b = legendre_prev2_reg; end
            S_T1:    begin mul_a = cur_reg; mul_b = $signed({38'b0, two_l_p1}); end
            S_G:     begin mul_a = sat48(acc_rd); mul_b = rd_gain_reg; end
            default: is_mul = 1'b0;
        endcase
    end

    always_comb
    begin
        is_div  = 1'b1;
        div_num = n_reg;
        div_den = dl_reg;
        case (state_reg)
            S_D1:    div_den = DEN_W'(multipole_count_reg);
            S_T2:    div_den = dl_reg;
            default: is_div = 1'b0;
        endcase
    end

    assign mul_start = is_mul && !issued_reg;
    assign div_start = is_div && !issued_reg;

    lbs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    lbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    // Band table: one write port, one registered read port.
    assign rd_addr = (state_reg >= S_LTOP) ? k_reg[BAND_W-1:0] : count_m1[BAND_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && (action == 1'b0)) begin
            first_table[band_slot] <= band_first;
            last_table[band_slot]  <= band_last;
            gain_table[band_slot]  <= band_gain;
        end
        rd_first_reg <= first_table[rd_addr];
        rd_last_reg  <= last_table[rd_addr];
        rd_gain_reg  <= gain_table[rd_addr];
    end

    assign emit_fin  = ({1'b0, b_reg} == count_m1);
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg           <= S_IDLE;
            band_count_reg      <= CNT_W'(1);
            count_reg           <= '0;
            issued_reg          <= 1'b0;
            out_valid_reg       <= 1'b0;
            cidx_reg            <= '0;
            step_reg            <= '0;
            k_reg               <= '0;
            b_reg               <= '0;
            multipole_count_reg <= '0;
            legendre_prev_reg   <= '0;
            legendre_prev2_reg  <= '0;
            pair_cosine_reg     <= '0;
        end
        else begin
            if (cfg_write && (paddr[2] == 1'b0))
                band_count_reg <= pwdata[CNT_W-1:0];

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (mul_start || div_start)
                issued_reg <= 1'b1;
            else if ((is_mul && mul_done) || (is_div && div_done))
                issued_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (accept && (action == 1'b1) && (count_in != '0)) begin
                        count_reg <= count_in;
                        cidx_reg  <= '0;
                        state_reg <= S_RED;
                    end
                end
                S_RED: begin
                    step_reg  <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                        if (cidx_reg == 2'd2) begin
                            state_reg <= S_X1;
                        end
                        else begin
                            cidx_reg  <= cidx_reg + 2'd1;
                            state_reg <= S_RED;
                        end
                    end
                end
                S_X1: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_X2;
                end
                S_X2: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_X3;
                end
                S_X3: begin
                    if (issued_reg && mul_done) begin
                        pair_cosine_reg     <= 48'(xclamp) <<< 10;
                        legendre_prev_reg   <= Q40_ONE;
                        legendre_prev2_reg  <= '0;
                        multipole_count_reg <= ELL_W'(1);
                        k_reg               <= '0;
                        state_reg           <= S_LTOP;
                    end
                end
                S_LTOP: begin
                    if (multipole_count_reg > stop_reg) begin
                        b_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (multipole_count_reg == ELL_W'(1)) begin
                        state_reg <= S_UPD;
                    end
                    else begin
                        state_reg <= S_M1;
                    end
                end
                S_M1: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_M2;
                end
                S_M2: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_M3;
                end
                S_M3: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_D1;
                end
                S_D1: begin
                    if (issued_reg && div_done)
                        state_reg <= S_UPD;
                end
                S_UPD: begin
                    legendre_prev2_reg <= legendre_prev_reg;
                    legendre_prev_reg  <= cur_reg;
                    state_reg          <= takes_term ? S_T1 : S_NEXT;
                end
                S_T1: begin
                    if (issued_reg && mul_done)
                        state_reg <= S_T2;
                end
                S_T2: begin
                    if (issued_reg && div_done)
                        state_reg <= (multipole_count_reg == rd_last_reg) ? S_G : S_NEXT;
                end
                S_G: begin
                    if (issued_reg && mul_done) begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    multipole_count_reg <= multipole_count_reg + ELL_W'(1);
                    state_reg           <= S_LTOP;
                end
                S_EMIT: begin
                    if (emit_load) begin
                        b_reg <= b_reg + BAND_W'(1);
                        if (emit_fin)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Working values of the datapath.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            deca_reg <= dec_a;
            decb_reg <= dec_b;
            rad_reg  <= $signed({1'b0, ra_a}) - $signed({1'b0, ra_b});
        end

        case (state_reg)
            S_RED: begin
                cm_reg   <= red.m;
                flip_reg <= red.flip;
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
            end
            S_ROT: begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                cm_reg <= cm_next;
                if (step_reg == 5'(CORDIC_STEPS - 1)) begin
                    case (cidx_reg)
                        2'd0: begin
                            sa_reg <= cy_next;
                            ca_reg <= cos_out;
                        end
                        2'd1: begin
                            sb_reg <= cy_next;
                            cb_reg <= cos_out;
                        end
                        default: cd_reg <= cos_out;
                    endcase
                end
            end
            S_X1: begin
                if (mul_done)
                    t1_reg <= 48'(floor30(prod));
            end
            S_X2: begin
                if (mul_done)
                    t2_reg <= 48'(floor30(prod));
            end
            S_X3: begin
                if (mul_done) begin
                    stop_reg  <= (rd_last_reg > ELL_W'(MAX_MULTIPOLE)) ?
                                 ELL_W'(MAX_MULTIPOLE) : rd_last_reg;
                    dl_reg    <= DEN_W'(4);
                    total_reg <= '0;
                    for (int i = 0; i < MAX_BANDS; i++)
                        acc_reg[i] <= '0;
                end
            end
            S_LTOP: begin
                cur_reg <= pair_cosine_reg;
            end
            S_M1: begin
                if (mul_done)
                    m_reg <= 48'(trunc_shift(prod, 40));
            end
            S_M2: begin
                if (mul_done)
                    p1_reg <= trunc_shift(prod, 0);
            end
            S_M3: begin
                if (mul_done)
                    n_reg <= p1_reg - trunc_shift(prod, 0);
            end
            S_D1: begin
                if (div_done)
                    cur_reg <= sat48(quo);
            end
            S_T1: begin
                if (mul_done)
                    n_reg <= trunc_shift(prod, 0);
            end
            S_T2: begin
                if (div_done)
                    acc_reg[k_reg[BAND_W-1:0]] <= acc_rd + quo;
            end
            S_G: begin
                if (mul_done)
                    total_reg <= sat_add64(total_reg, trunc_shift(prod, 32));
            end
            S_NEXT: begin
                dl_reg <= dl_reg + DEN_W'({multipole_count_reg + ELL_W'(1), 2'b00});
            end
            default: begin
            end
        endcase

        if (emit_load) begin
            ob_index_reg  <= b_reg;
            ob_signal_reg <= sat48(acc_rd);
            ob_total_reg  <= emit_fin ? total_reg : 64'sd0;
            ob_last_reg   <= emit_fin;
        end
    end

    assign out_valid      = out_valid_reg;
    assign band_index     = ob_index_reg;
    assign band_signal    = ob_signal_reg;
    assign weighted_total = ob_total_reg;
    assign last           = ob_last_reg;

endmodule

FILE: src/lbs_mul.sv
module lbs_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [lbs_pkg::MUL_W-1:0] a,
    input  logic signed [lbs_pkg::MUL_W-1:0] b,
    output logic                      done,
    output lbs_pkg::lbs_prod_t        prod
);
    import lbs_pkg::*;

    localparam int HW = MUL_W / 2;

    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W-1:0]  ua_reg;
    logic [MUL_W-1:0]  ub_reg;
    logic              neg_reg;
    logic [MUL_W-1:0]  pp_reg;
    logic [1:0]        ppsh_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [HW-1:0]     pa;
    logic [HW-1:0]     pb;
    logic [PROD_W-1:0] pp_shifted;

    // Four partial products of 24-bit halves, low by low first.
    assign pa = cnt_reg[1] ? ua_reg[MUL_W-1:HW] : ua_reg[HW-1:0];
    assign pb = cnt_reg[0] ? ub_reg[MUL_W-1:HW] : ub_reg[HW-1:0];

    always_comb
    begin
        case (ppsh_reg)
            2'd0:    pp_shifted = {{(PROD_W-MUL_W){1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{(PROD_W-MUL_W){1'b0}}, pp_reg} << HW;
            2'd2:    pp_shifted = {{(PROD_W-MUL_W){1'b0}}, pp_reg} << MUL_W;
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            ua_reg  <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
            ub_reg  <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
            neg_reg <= a[MUL_W-1] ^ b[MUL_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                pp_reg   <= pa * pb;
                ppsh_reg <= 2'(cnt_reg[1] + cnt_reg[0]);
            end
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done     = done_reg;
    assign prod.neg = neg_reg;
    assign prod.mag = acc_reg;

endmodule

FILE: src/lbs_div.sv
module lbs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [63:0]                num,
    input  logic [lbs_pkg::DEN_W-1:0]         den,
    output logic                              done,
    output logic signed [63:0]                quo
);
    import lbs_pkg::*;

    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_STEPS-1:0] mag_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W:0]       trial;
    logic                 fits;
    logic [63:0]          num_abs;
    logic [63:0]          q_abs;

    assign num_abs = num[63] ? 64'(-num) : 64'(num);
    assign trial   = {rem_reg, mag_reg[DIV_STEPS-1]};
    assign fits    = trial >= {1'b0, den_reg};
    assign q_abs   = {{(64-DIV_STEPS){1'b0}}, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else begin
            done_reg <= 1'b0;
        end
    end

    // Restoring division: the quotient bits shift in as the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (start) begin
            neg_reg <= num[63];
            mag_reg <= num_abs[DIV_STEPS-1:0];
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            mag_reg <= {mag_reg[DIV_STEPS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? $signed(-q_abs) : $signed(q_abs);

endmodule

FILE: dv/legendre_band_signal_tb.sv
module legendre_band_signal_tb;
    import lbs_pkg::*;

    typedef enum logic [0:0] {ACT_TABLE = 1'b0, ACT_PAIR = 1'b1} action_e;

    localparam logic [2:0] BAND_COUNT_ADDR = 3'd0;
    localparam int         RA_MAX          = 23592959;
    localparam int         DEC_MAX         = 5898240;
    localparam int         CYCLE_LIMIT     = 4000000;

    typedef struct {
        action_e            act;
        logic [3:0]         slot;
        logic [8:0]         first;
        logic [8:0]         final_l;
        logic signed [47:0] gain;
        logic [24:0]        ra_a;
        logic signed [23:0] dec_a;
        logic [24:0]        ra_b;
        logic signed [23:0] dec_b;
    } word_t;

    typedef struct {
        logic [3:0]         idx;
        logic signed [47:0] sig;
        logic signed [63:0] tot;
        logic               fin;
    } band_result_t;

    class band_scoreboard;
        logic [4:0]   band_count;
        logic [8:0]   first_tab[MAX_BANDS];
        logic [8:0]   last_tab[MAX_BANDS];
        longint       gain_tab[MAX_BANDS];
        band_result_t awaited[$];
        int           errors;
        int           pairs;
        int           writes;
        int           checked;
        bit           silent;

        function new();
            band_count = 5'd1;
            errors     = 0;
            pairs      = 0;
            writes     = 0;
            checked    = 0;
            silent     = 1'b0;
        endfunction

        function longint clip48(longint v);
            if (v > S48_MAX)
                return S48_MAX;
            if (v < S48_MIN)
                return S48_MIN;
            return v;
        endfunction

        function longint add_clip64(longint a, longint b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        // Magnitude product shifted down, sign applied afterwards: rounds toward zero.
        function longint scaled_product(longint a, longint b, int sh);
            logic [127:0] p;
            logic [63:0]  ua;
            logic [63:0]  ub;
            logic [63:0]  r;
            bit           neg;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? 64'(-a) : 64'(a);
            ub  = (b < 0) ? 64'(-b) : 64'(b);
            p   = {64'b0, ua} * {64'b0, ub};
            r   = 64'(p >> sh);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function void rotate_deg(input longint a, output longint s, output longint c);
            longint atan_q16[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
                117308, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                14, 7};
            longint m;
            longint x;
            longint y;
            longint nx;
            bit     flip;
            m    = a % 23592960;
            x    = 652032875;
            y    = 0;
            flip = 1'b0;
            if (m < 0)
                m += 23592960;
            if (m >= 11796480)
                m -= 23592960;
            if (m > 5898240)
            begin
                m    = 11796480 - m;
                flip = 1'b1;
            end
            else if (m < -5898240)
            begin
                m    = -11796480 - m;
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (m >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    m -= atan_q16[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    m += atan_q16[i];
                end
                x = nx;
            end
            s = y;
            c = flip ? -x : x;
        endfunction

        function void note_word(word_t w);
            longint       acc[MAX_BANDS];
            longint       sa, ca, sb, cb, sd, cd, x, total, cur, term, prev, prev2, l;
            int           cnt;
            int           k;
            int           stop;
            band_result_t r;
            if (w.act == ACT_TABLE)
            begin
                first_tab[w.slot] = w.first;
                last_tab[w.slot]  = w.final_l;
                gain_tab[w.slot]  = longint'(w.gain);
                writes++;
                return;
            end
            pairs++;
            cnt = (band_count > MAX_BANDS) ? MAX_BANDS : int'(band_count);
            if (cnt == 0)
            begin
                silent = 1'b1;
                return;
            end
            rotate_deg(longint'(w.dec_a), sa, ca);
            rotate_deg(longint'(w.dec_b), sb, cb);
            rotate_deg(longint'(w.ra_a) - longint'(w.ra_b), sd, cd);
            x = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
            if (x > Q30_ONE)
                x = Q30_ONE;
            if (x < -Q30_ONE)
                x = -Q30_ONE;
            x *= 1024;
            for (int b = 0; b < cnt; b++)
                acc[b] = 0;
            stop = last_tab[cnt-1];
            if (stop > MAX_MULTIPOLE)
                stop = MAX_MULTIPOLE;
            prev  = longint'(Q40_ONE);
            prev2 = 0;
            k     = 0;
            total = 0;
            for (int ell = 1; ell <= stop; ell++)
            begin
                l = ell;
                if (ell == 1)
                    cur = x;
                else
                begin
                    cur = (2*l - 1) * scaled_product(x, prev, 40) - (l - 1) * prev2;
                    cur = clip48(cur / l);
                end
                prev2 = prev;
                prev  = cur;
                if (k >= cnt || ell < first_tab[k])
                    continue;
                term   = (cur * (2*l + 1)) / (2*l*(l + 1));
                acc[k] += term;
                if (ell == last_tab[k])
                begin
                    total = add_clip64(total, scaled_product(clip48(acc[k]), gain_tab[k], 32));
                    k++;
                end
            end
            for (int b = 0; b < cnt; b++)
            begin
                r.idx = 4'(b);
                r.sig = 48'(clip48(acc[b]));
                r.fin = (b + 1 == cnt);
                r.tot = r.fin ? total : 64'sd0;
                awaited.push_back(r);
            end
        endfunction

        function void check_result(logic [3:0] idx, logic signed [47:0] sig,
                                   logic signed [63:0] tot, logic fin);
            band_result_t e;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited: band_index %0d", idx);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (idx !== e.idx)
            begin
                $error("band_index: expected %0d, got %0d", e.idx, idx);
                errors++;
            end
            if (sig !== e.sig)
            begin
                $error("band_signal: expected %0d, got %0d", e.sig, sig);
                errors++;
            end
            if (tot !== e.tot)
            begin
                $error("weighted_total: expected %0d, got %0d", e.tot, tot);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $error("last: expected %0d, got %0d", e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [0:0]         action = ACT_TABLE;
    logic [3:0]         band_slot = '0;
    logic [8:0]         band_first = 9'd1;
    logic [8:0]         band_last = 9'd1;
    logic signed [47:0] band_gain = '0;
    logic [24:0]        ra_a = '0;
    logic signed [23:0] dec_a = '0;
    logic [24:0]        ra_b = '0;
    logic signed [23:0] dec_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         band_index;
    logic signed [47:0] band_signal;
    logic signed [63:0] weighted_total;
    logic               last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    band_scoreboard sb = new();
    int             cycles = 0;
    bit             squeeze_done = 1'b0;
    int             active_count = 1;

    legendre_band_signal i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL legendre_band_signal");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial
    begin
        int hold;
        int pick;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(band_index, band_signal, weighted_total, last);
            if (!squeeze_done && sb.pairs >= 30)
            begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                hold = 10000;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    out_stall <= 1'b0;
                    hold = $urandom_range(0, 30);
                end
                else if (pick < 90)
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic send_word(input word_t w);
        int pick;
        int gap;
        in_valid   <= 1'b1;
        action     <= w.act;
        band_slot  <= w.slot;
        band_first <= w.first;
        band_last  <= w.final_l;
        band_gain  <= w.gain;
        ra_a       <= w.ra_a;
        dec_a      <= w.dec_a;
        ra_b       <= w.ra_b;
        dec_b      <= w.dec_b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
        pick = $urandom_range(0, 99);
        gap  = (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_band_count(input logic [4:0] v);
        int settle;
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        // A pair sent with no bands in use starts no recurrence in the block.
        settle = sb.silent ? 40000 : 300;
        sb.silent = 1'b0;
        repeat (settle) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BAND_COUNT_ADDR;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.band_count = v;
        active_count  = (v > MAX_BANDS) ? MAX_BANDS : int'(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic word_t table_word(int slot, int first, int fin, longint gain);
        word_t w;
        w.act     = ACT_TABLE;
        w.slot    = 4'(slot);
        w.first   = 9'(first);
        w.final_l = 9'(fin);
        w.gain    = 48'(gain);
        w.ra_a    = 25'($urandom);
        w.dec_a   = 24'($urandom);
        w.ra_b    = 25'($urandom);
        w.dec_b   = 24'($urandom);
        return w;
    endfunction

    function automatic word_t pair_word(int raa, int deca, int rab, int decb);
        word_t w;
        w.act     = ACT_PAIR;
        w.slot    = 4'($urandom);
        w.first   = 9'($urandom);
        w.final_l = 9'($urandom);
        w.gain    = 48'({$urandom, $urandom});
        w.ra_a    = 25'(raa);
        w.dec_a   = 24'(deca);
        w.ra_b    = 25'(rab);
        w.dec_b   = 24'(decb);
        return w;
    endfunction

    function automatic int rand_dec();
        return $urandom_range(0, 2*DEC_MAX) - DEC_MAX;
    endfunction

    function automatic word_t random_pair();
        int pick;
        int raa;
        int deca;
        pick = $urandom_range(0, 99);
        raa  = $urandom_range(0, RA_MAX);
        deca = rand_dec();
        if (pick < 10)
            return pair_word(raa, deca, raa, deca);
        if (pick < 20)
            return pair_word(raa, deca, (raa + 11796480) % 23592960, -deca);
        if (pick < 28)
            return pair_word(raa, DEC_MAX, $urandom_range(0, RA_MAX), -DEC_MAX);
        return pair_word(raa, deca, $urandom_range(0, RA_MAX), rand_dec());
    endfunction

    function automatic word_t random_table(int cnt);
        int     pick;
        int     slot;
        int     first;
        int     fin;
        longint gain;
        slot = $urandom_range(0, MAX_BANDS - 1);
        pick = $urandom_range(0, 99);
        first = (pick < 70) ? $urandom_range(1, 12) :
                (pick < 95) ? $urandom_range(1, 40) : $urandom_range(1, 256);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            fin = first + $urandom_range(0, 8);
        else
            fin = $urandom_range(1, 20);
        // Long recurrences only on bands that do not set the run length.
        if (slot != cnt - 1 && $urandom_range(0, 99) < 5)
            fin = $urandom_range(0, 1) ? 256 : $urandom_range(1, 256);
        if (fin > 256 || (slot == cnt - 1 && fin > 24))
            fin = (slot == cnt - 1) ? $urandom_range(1, 24) : 256;
        pick = $urandom_range(0, 99);
        gain = (pick < 5) ? S48_MAX : (pick < 10) ? S48_MIN : longint'($signed(48'({$urandom,
               $urandom})));
        return table_word(slot, first, fin, gain);
    endfunction

    initial
    begin
        logic [4:0] settings[7];
        settings = '{5'd1, 5'd16, 5'd5, 5'd2, 5'd16, 5'd9, 5'd31};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: band closing at l = 1, inverted range, extreme gains and ends.
        send_word(table_word(0, 1, 1, S48_MAX));
        send_word(table_word(1, 2, 3, S48_MIN));
        send_word(table_word(2, 3, 2, S48_MAX));
        for (int s = 3; s < MAX_BANDS - 1; s++)
            send_word(table_word(s, s, s + 2, longint'($signed(48'({$urandom, $urandom})))));
        send_word(table_word(15, 256, 256, S48_MAX));
        send_word(pair_word(0, DEC_MAX, RA_MAX, -DEC_MAX));
        send_word(pair_word(RA_MAX, 0, 0, 0));
        write_band_count(5'd16);
        send_word(pair_word(0, 0, 11796480, 0));
        send_word(pair_word(1234567, -DEC_MAX, 1234567, -DEC_MAX));
        write_band_count(5'd0);
        send_word(pair_word(0, 0, 0, 0));
        write_band_count(5'd31);
        send_word(table_word(15, 1, 9, S48_MIN));
        send_word(pair_word(5898240, 3000000, 17694720, -3000000));

        foreach (settings[p])
        begin
            write_band_count(settings[p]);
            send_word(table_word(active_count - 1, $urandom_range(1, 6),
                                 $urandom_range(6, 14), S48_MAX));
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 1))
                    send_word(random_pair());
                else
                    send_word(random_table(active_count));
            end
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Covered %0d position pairs and %0d band table writes over %0d band counts;",
                 sb.pairs, sb.writes, $size(settings) + 3);
        $display("%0d band result words checked, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS legendre_band_signal");
        else
            $display("FAIL legendre_band_signal");
        $finish;
    end

endmodule
